### src/m4mti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4mti_pkg
// Shared widths, codes, lane command type and index helpers of the 4x4 unit.
// ----------------------------------------------------------------------------
package m4mti_pkg;

   localparam int VALUE_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int LANES     = 4;
   localparam int MUL_W     = VALUE_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int ACC_W     = 136;
   localparam int RND_W     = 2 * VALUE_W + 4;
   localparam int D2_W      = 2 * VALUE_W + 1;
   localparam int ADJ_W     = 3 * VALUE_W + 1;
   localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;
   localparam int DEN_W     = 130;
   localparam int DIV_STEPS = VALUE_W + 1;
   localparam int DIV_W     = DEN_W + DIV_STEPS + 1;
   localparam int QMAG_W    = DIV_STEPS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [2:0] MODE_LOAD_CUR = 3'd0;
   localparam logic [2:0] MODE_LOAD_OPD = 3'd1;
   localparam logic [2:0] MODE_MUL      = 3'd2;
   localparam logic [2:0] MODE_VEC4     = 3'd3;
   localparam logic [2:0] MODE_POINT    = 3'd4;
   localparam logic [2:0] MODE_INV      = 3'd5;

   typedef struct packed {
      logic                    vld;
      logic                    clr;
      logic                    sub;
      logic [1:0]              shift;
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } lane_op_type;

   // column pairs of the 2x2 minors: 01 02 03 12 13 23
   function automatic logic [1:0] pair_lo(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_hi(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0:       r = 2'd1;
         3'd1, 3'd3: r = 2'd2;
         default:    r = 2'd3;
      endcase
      return r;
   endfunction

   // n-th column that is left when column j is dropped
   function automatic logic [1:0] col_skip(input logic [1:0] j, input logic [1:0] n);
      return (n >= j) ? n + 2'd1 : n;
   endfunction

   // pair index of the two columns other than j and k
   function automatic logic [2:0] cof_pair(input logic [1:0] j, input logic [1:0] k);
      logic [3:0] mask;
      logic [2:0] r;
      mask = ~((4'd1 << j) | (4'd1 << k));
      unique case (mask)
         4'b0011: r = 3'd0;
         4'b0101: r = 3'd1;
         4'b1001: r = 3'd2;
         4'b0110: r = 3'd3;
         4'b1010: r = 3'd4;
         4'b1100: r = 3'd5;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### src/matrix4_multiply_transform_invert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_multiply_transform_invert
// 4x4 Q16.16 matrix unit: load, multiply, transform and cofactor inverse.
// ----------------------------------------------------------------------------
// load: taken straight from idle, no result. transform: 4 MAC steps, drain, one beat.
// multiply: per column, 4 MAC steps on four lanes, drain, 4 beats; 16 beats in all.
// invert: 2x2 minors, cofactors and the determinant on the lanes, then one beat
//   per element from the single bit-serial divider, or one singular beat if the determinant is zero.
// receiver cannot stall; synchronous reset zeroes both matrices and control.
// ----------------------------------------------------------------------------
module matrix4_multiply_transform_invert (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [2:0]                           req_mode,
   input  wire  [3:0]                           req_elem_index,
   input  wire  signed [m4mti_pkg::VALUE_W-1:0] req_elem_value,
   input  wire  signed [m4mti_pkg::VALUE_W-1:0] req_vec_x,
   input  wire  signed [m4mti_pkg::VALUE_W-1:0] req_vec_y,
   input  wire  signed [m4mti_pkg::VALUE_W-1:0] req_vec_z,
   input  wire  signed [m4mti_pkg::VALUE_W-1:0] req_vec_w,
   output logic                                 rsp_valid,
   output logic [3:0]                           rsp_out_index,
   output logic signed [m4mti_pkg::VALUE_W-1:0] rsp_out_value,
   output logic signed [m4mti_pkg::VALUE_W-1:0] rsp_res_x,
   output logic signed [m4mti_pkg::VALUE_W-1:0] rsp_res_y,
   output logic signed [m4mti_pkg::VALUE_W-1:0] rsp_res_z,
   output logic signed [m4mti_pkg::VALUE_W-1:0] rsp_res_w,
   output logic                                 rsp_singular,
   output logic                                 rsp_last
);
   import m4mti_pkg::*;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_MUL_ISS  = 5'd1;
   localparam logic [4:0] ST_MUL_WAIT = 5'd2;
   localparam logic [4:0] ST_MUL_EMIT = 5'd3;
   localparam logic [4:0] ST_TRF_ISS  = 5'd4;
   localparam logic [4:0] ST_TRF_WAIT = 5'd5;
   localparam logic [4:0] ST_TRF_EMIT = 5'd6;
   localparam logic [4:0] ST_D2_ISS   = 5'd7;
   localparam logic [4:0] ST_D2_WAIT  = 5'd8;
   localparam logic [4:0] ST_D2_CAP   = 5'd9;
   localparam logic [4:0] ST_COF_ISS  = 5'd10;
   localparam logic [4:0] ST_COF_WAIT = 5'd11;
   localparam logic [4:0] ST_COF_CAP  = 5'd12;
   localparam logic [4:0] ST_DET_ISS  = 5'd13;
   localparam logic [4:0] ST_DET_WAIT = 5'd14;
   localparam logic [4:0] ST_DET_SUM  = 5'd15;
   localparam logic [4:0] ST_DET_CHK  = 5'd16;
   localparam logic [4:0] ST_DIV_GO   = 5'd17;
   localparam logic [4:0] ST_DIV_WAIT = 5'd18;

   // matrices: index = row + 4 * column
   logic signed [VALUE_W-1:0] cur_ff [16];
   logic signed [VALUE_W-1:0] opd_ff [16];
   logic signed [VALUE_W-1:0] vec_ff [4];
   logic signed [D2_W-1:0]    d2_ff  [12];
   logic signed [ADJ_W-1:0]   adj_ff [16];
   logic signed [ACC_W-1:0]   s01_ff;
   logic signed [ACC_W-1:0]   s23_ff;
   logic signed [ACC_W-1:0]   det_ff;
   logic signed [ACC_W-1:0]   det_sum;
   logic                      pt_ff;
   logic                      neg_ff;

   logic [4:0] state_ff, state_in;
   logic [1:0] col_ff, col_in;
   logic [2:0] stp_ff, stp_in;
   logic [3:0] elem_ff, elem_in;

   logic                      cur_we;
   logic [3:0]                cur_wa;
   logic signed [VALUE_W-1:0] cur_wd;
   logic                      opd_we;
   logic                      vec_we;
   logic                      det_we;
   logic                      div_start;
   logic                      div_done;
   logic [QMAG_W-1:0]         div_mag;
   logic                      div_ovf;
   logic signed [ADJ_W-1:0]   adj_sel;
   logic [ADJ_W-1:0]          adj_abs;
   logic [ACC_W-1:0]          det_abs;
   logic [NUM_W-1:0]          div_num;
   logic signed [VALUE_W-1:0] div_val;

   lane_op_type             lane_op  [LANES];
   logic signed [ACC_W-1:0] lane_acc [LANES];
   logic signed [VALUE_W-1:0] rnd    [LANES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3:0]                rsp_index_ff, rsp_index_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic signed [VALUE_W-1:0] rsp_res_ff [4];
   logic signed [VALUE_W-1:0] rsp_res_in [4];
   logic                      rsp_sing_ff, rsp_sing_in;
   logic                      rsp_last_ff, rsp_last_in;

   function automatic logic signed [VALUE_W-1:0] round_frac(input logic signed [RND_W-1:0] s);
      logic             neg;
      logic [RND_W-1:0] m;
      logic [RND_W-1:0] q;
      logic [RND_W-1:0] lim;
      neg = s[RND_W-1];
      m   = neg ? RND_W'(-s) : RND_W'(s);
      q   = (m + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      lim = neg ? (RND_W'(1) << (VALUE_W - 1)) : (RND_W'(1) << (VALUE_W - 1)) - RND_W'(1);
      if (q > lim) begin
         q = lim;
      end
      return neg ? VALUE_W'(-q) : VALUE_W'(q);
   endfunction

   // ------------------------------------------------------------------ lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      m4mti_lane u_lane (
         .clock (clock),
         .reset (reset),
         .op    (lane_op[g]),
         .acc   (lane_acc[g])
      );
      assign rnd[g] = round_frac(RND_W'(lane_acc[g]));
   end

   always_comb begin
      logic [1:0]            ln;
      logic [3:0]            d;
      logic                  hi;
      logic [2:0]            pr;
      logic [1:0]            r0;
      logic [1:0]            ci;
      logic [1:0]            cj;
      logic [1:0]            nn;
      logic [1:0]            kn;
      logic [1:0]            pp;
      logic [3:0]            dsel;
      logic signed [D2_W-1:0]  pv;
      logic signed [ADJ_W-1:0] av;
      for (int l = 0; l < LANES; l++) begin
         ln = 2'(l);
         d  = {col_ff, ln};
         hi = (d >= 4'd6);
         pr = hi ? 3'(d - 4'd6) : d[2:0];
         r0 = hi ? 2'd2 : 2'd0;
         ci = pair_lo(pr);
         cj = pair_hi(pr);
         nn = stp_ff[2:1];
         kn = col_skip(ln, nn);
         pp = col_ff ^ 2'd1;
         dsel = (col_ff < 2'd2) ? 4'(cof_pair(ln, kn)) + 4'd6 : 4'(cof_pair(ln, kn));
         pv = d2_ff[dsel];
         av = adj_ff[{ln, 2'd0}];
         lane_op[l] = '0;
         unique case (state_ff)
            ST_MUL_ISS: begin
               lane_op[l].vld = 1'b1;
               lane_op[l].clr = (stp_ff == 3'd0);
               lane_op[l].a   = MUL_W'(cur_ff[{col_ff, stp_ff[1:0]}]);
               lane_op[l].b   = MUL_W'(opd_ff[{stp_ff[1:0], ln}]);
            end
            ST_TRF_ISS: begin
               lane_op[l].vld = 1'b1;
               lane_op[l].clr = (stp_ff == 3'd0);
               lane_op[l].a   = MUL_W'(cur_ff[{stp_ff[1:0], ln}]);
               lane_op[l].b   = MUL_W'(vec_ff[stp_ff[1:0]]);
            end
            ST_D2_ISS: begin
               lane_op[l].vld = 1'b1;
               lane_op[l].clr = (stp_ff == 3'd0);
               lane_op[l].sub = stp_ff[0];
               if (stp_ff[0]) begin
                  lane_op[l].a = MUL_W'(cur_ff[{cj, r0}]);
                  lane_op[l].b = MUL_W'(cur_ff[{ci, r0 | 2'd1}]);
               end else begin
                  lane_op[l].a = MUL_W'(cur_ff[{ci, r0}]);
                  lane_op[l].b = MUL_W'(cur_ff[{cj, r0 | 2'd1}]);
               end
            end
            ST_COF_ISS: begin
               // cofactor of row col_ff, column ln, expanded along the partner row
               lane_op[l].vld   = 1'b1;
               lane_op[l].clr   = (stp_ff == 3'd0);
               lane_op[l].sub   = nn[0] ^ col_ff[0] ^ ln[0];
               lane_op[l].shift = {1'b0, stp_ff[0]};
               lane_op[l].a     = MUL_W'(cur_ff[{kn, pp}]);
               lane_op[l].b     = stp_ff[0] ? pv[D2_W-1:VALUE_W] : {1'b0, pv[VALUE_W-1:0]};
            end
            ST_DET_ISS: begin
               lane_op[l].vld   = 1'b1;
               lane_op[l].clr   = (stp_ff == 3'd0);
               lane_op[l].shift = stp_ff[1:0];
               lane_op[l].a     = MUL_W'(cur_ff[{2'd0, ln}]);
               unique case (stp_ff[1:0])
                  2'd0:    lane_op[l].b = {1'b0, av[VALUE_W-1:0]};
                  2'd1:    lane_op[l].b = {1'b0, av[2*VALUE_W-1:VALUE_W]};
                  default: lane_op[l].b = av[ADJ_W-1:2*VALUE_W];
               endcase
            end
            default: begin
               lane_op[l] = '0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- divider
   assign adj_sel = adj_ff[elem_ff];
   assign adj_abs = adj_sel[ADJ_W-1] ? ADJ_W'(-adj_sel) : ADJ_W'(adj_sel);
   assign det_abs = det_ff[ACC_W-1] ? ACC_W'(-det_ff) : ACC_W'(det_ff);
   assign div_num = {adj_abs, {(2 * FRAC_BITS){1'b0}}};
   assign det_sum = s01_ff + s23_ff;

   m4mti_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_abs[DEN_W-1:0]),
      .done  (div_done),
      .mag   (div_mag),
      .ovf   (div_ovf)
   );

   always_comb begin
      logic [QMAG_W-1:0] lim;
      logic [QMAG_W-1:0] m;
      lim = neg_ff ? (QMAG_W'(1) << (VALUE_W - 1))
                   : (QMAG_W'(1) << (VALUE_W - 1)) - QMAG_W'(1);
      m   = (div_ovf || (div_mag > lim)) ? lim : div_mag;
      div_val = neg_ff ? VALUE_W'(-m) : VALUE_W'(m);
   end

   // -------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      stp_in       = stp_ff;
      elem_in      = elem_ff;
      cur_we       = 1'b0;
      cur_wa       = req_elem_index;
      cur_wd       = req_elem_value;
      opd_we       = 1'b0;
      vec_we       = 1'b0;
      det_we       = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_index_in = '0;
      rsp_value_in = '0;
      rsp_sing_in  = 1'b0;
      rsp_last_in  = 1'b0;
      for (int k = 0; k < 4; k++) begin
         rsp_res_in[k] = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            col_in  = '0;
            stp_in  = '0;
            elem_in = '0;
            if (start) begin
               unique case (req_mode)
                  MODE_LOAD_CUR: cur_we = 1'b1;
                  MODE_LOAD_OPD: opd_we = 1'b1;
                  MODE_MUL:      state_in = ST_MUL_ISS;
                  MODE_VEC4, MODE_POINT: begin
                     vec_we   = 1'b1;
                     state_in = ST_TRF_ISS;
                  end
                  MODE_INV:      state_in = ST_D2_ISS;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL_ISS: begin
            if (stp_ff == 3'd3) begin
               stp_in   = '0;
               state_in = ST_MUL_WAIT;
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_MUL_WAIT: state_in = ST_MUL_EMIT;
         ST_MUL_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = {col_ff, stp_ff[1:0]};
            rsp_value_in = rnd[stp_ff[1:0]];
            rsp_last_in  = (col_ff == 2'd3) && (stp_ff == 3'd3);
            cur_we       = 1'b1;
            cur_wa       = {col_ff, stp_ff[1:0]};
            cur_wd       = rnd[stp_ff[1:0]];
            if (stp_ff == 3'd3) begin
               stp_in = '0;
               if (col_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 2'd1;
                  state_in = ST_MUL_ISS;
               end
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_TRF_ISS: begin
            if (stp_ff == 3'd3) begin
               stp_in   = '0;
               state_in = ST_TRF_WAIT;
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_TRF_WAIT: state_in = ST_TRF_EMIT;
         ST_TRF_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_res_in[0] = rnd[0];
            rsp_res_in[1] = rnd[1];
            rsp_res_in[2] = rnd[2];
            rsp_res_in[3] = pt_ff ? '0 : rnd[3];
            state_in      = ST_IDLE;
         end
         ST_D2_ISS: begin
            if (stp_ff == 3'd1) begin
               stp_in   = '0;
               state_in = ST_D2_WAIT;
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_D2_WAIT: state_in = ST_D2_CAP;
         ST_D2_CAP: begin
            if (col_ff == 2'd2) begin
               col_in   = '0;
               state_in = ST_COF_ISS;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = ST_D2_ISS;
            end
         end
         ST_COF_ISS: begin
            if (stp_ff == 3'd5) begin
               stp_in   = '0;
               state_in = ST_COF_WAIT;
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_COF_WAIT: state_in = ST_COF_CAP;
         ST_COF_CAP: begin
            if (col_ff == 2'd3) begin
               col_in   = '0;
               state_in = ST_DET_ISS;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = ST_COF_ISS;
            end
         end
         ST_DET_ISS: begin
            if (stp_ff == 3'd2) begin
               stp_in   = '0;
               state_in = ST_DET_WAIT;
            end else begin
               stp_in = stp_ff + 3'd1;
            end
         end
         ST_DET_WAIT: state_in = ST_DET_SUM;
         ST_DET_SUM:  state_in = ST_DET_CHK;
         ST_DET_CHK: begin
            det_we = 1'b1;
            if (det_sum == '0) begin
               rsp_valid_in = 1'b1;
               rsp_sing_in  = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               elem_in  = '0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = elem_ff;
               rsp_value_in = div_val;
               rsp_last_in  = (elem_ff == 4'd15);
               cur_we       = 1'b1;
               cur_wa       = elem_ff;
               cur_wd       = div_val;
               if (elem_ff == 4'd15) begin
                  state_in = ST_IDLE;
               end else begin
                  elem_in  = elem_ff + 4'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         stp_ff       <= '0;
         elem_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            cur_ff[k] <= '0;
            opd_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         stp_ff       <= stp_in;
         elem_ff      <= elem_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cur_we) begin
            cur_ff[cur_wa] <= cur_wd;
         end
         if (opd_we) begin
            opd_ff[req_elem_index] <= req_elem_value;
         end
      end
   end

   // working storage of the transform and the inverse, and output beat registers
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         vec_ff[3] <= (req_mode == MODE_POINT) ? VALUE_W'(1) << FRAC_BITS : req_vec_w;
         pt_ff     <= (req_mode == MODE_POINT);
      end
      if (state_ff == ST_D2_CAP) begin
         for (int l = 0; l < LANES; l++) begin
            d2_ff[{col_ff, 2'(l)}] <= D2_W'(lane_acc[l]);
         end
      end
      if (state_ff == ST_COF_CAP) begin
         for (int l = 0; l < LANES; l++) begin
            adj_ff[{col_ff, 2'(l)}] <= ADJ_W'(lane_acc[l]);
         end
      end
      if (state_ff == ST_DET_SUM) begin
         s01_ff <= lane_acc[0] + lane_acc[1];
         s23_ff <= lane_acc[2] + lane_acc[3];
      end
      if (det_we) begin
         det_ff <= det_sum;
      end
      if (div_start) begin
         neg_ff <= adj_sel[ADJ_W-1] ^ det_ff[ACC_W-1];
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sing_ff  <= rsp_sing_in;
      rsp_last_ff  <= rsp_last_in;
      for (int k = 0; k < 4; k++) begin
         rsp_res_ff[k] <= rsp_res_in[k];
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_res_x     = rsp_res_ff[0];
   assign rsp_res_y     = rsp_res_ff[1];
   assign rsp_res_z     = rsp_res_ff[2];
   assign rsp_res_w     = rsp_res_ff[3];
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
`default_nettype wire

### src/m4mti_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4mti_lane
// One multiply-accumulate lane: registered 33x33 product, shifted wide add or subtract.
// ----------------------------------------------------------------------------
module m4mti_lane (
   input  wire                                 clock,
   input  wire                                 reset,
   input  m4mti_pkg::lane_op_type              op,
   output logic signed [m4mti_pkg::ACC_W-1:0]  acc
);
   import m4mti_pkg::*;

   logic                     vld_ff;
   logic                     clr_ff;
   logic                     sub_ff;
   logic [1:0]               shift_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  addend;

   assign prod_in = PROD_W'(op.a) * PROD_W'(op.b);

   always_comb begin
      addend = ACC_W'(prod_ff) <<< {shift_ff, 5'd0};
      if (clr_ff) begin
         acc_in = sub_ff ? -addend : addend;
      end else begin
         acc_in = sub_ff ? acc_ff - addend : acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= op.vld;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      clr_ff   <= op.clr;
      sub_ff   <= op.sub;
      shift_ff <= op.shift;
      if (vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

### src/m4mti_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m4mti_div
// Restoring divider, one quotient bit a cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module m4mti_div (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire  [m4mti_pkg::NUM_W-1:0]       num,
   input  wire  [m4mti_pkg::DEN_W-1:0]       den,
   output logic                              done,
   output logic [m4mti_pkg::QMAG_W-1:0]      mag,
   output logic                              ovf
);
   import m4mti_pkg::*;

   logic                 run_ff;
   logic                 fin_ff;
   logic                 done_ff;
   logic                 last_step;
   logic                 ge;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     dsh_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_STEPS-1:0] q_ff;
   logic [QMAG_W-1:0]    mag_ff;
   logic                 ovf_ff;
   logic                 rnd;

   assign last_step = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign ge        = (rem_ff >= dsh_ff);
   assign rnd       = ({rem_ff, 1'b0} >= (DIV_W + 1)'(den_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && last_step;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && last_step) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DIV_W'(num);
         dsh_ff <= DIV_W'(den) << (DIV_STEPS - 1);
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         // a quotient that needs more bits than we produce saturates anyway
         if (cnt_ff == '0) begin
            ovf_ff <= (rem_ff >= (DIV_W'(den_ff) << DIV_STEPS));
         end
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff   <= {q_ff[DIV_STEPS-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (fin_ff) begin
         mag_ff <= QMAG_W'(q_ff) + QMAG_W'(rnd);
      end
   end

   assign done = done_ff;
   assign mag  = mag_ff;
   assign ovf  = ovf_ff;

endmodule
`default_nettype wire
